@@ rtl/vtpg_pkg.sv @@
// ----------------------------------------------------------------------------
// vtpg_pkg
// Shared types, constants and the digit font of the test pattern generator.
// ----------------------------------------------------------------------------
package vtpg_pkg;

  // Field and register widths
  localparam int DIM_W      = 13;
  localparam int COORD_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int SCALE_W    = 7;
  localparam int GW_W       = 9;
  localparam int BOXH_W     = 10;
  localparam int PHASE_W    = 8;

  // Largest values of the derived box sizes
  localparam int SCALE_MAX  = 68;
  localparam int GW_MAX     = 408;

  // Usable frame dimension limits
  localparam logic [DIM_W-1:0] DIM_MIN   = 13'd2;
  localparam logic [DIM_W-1:0] DIM_MAX   = 13'd4096;
  localparam logic [DIM_W-1:0] WIDTH_RST = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

  // Video levels
  localparam logic [7:0] Y_LO    = 8'd16;
  localparam logic [7:0] Y_HI    = 8'd235;
  localparam logic [7:0] Y_SPAN  = 8'd219;
  localparam logic [7:0] NEUTRAL = 8'd128;
  localparam logic [7:0] C_BASE  = 8'd64;
  localparam logic [7:0] PHASE_STEP = 8'd3;

  // Scale is height / 60, done as a multiply by a reciprocal
  localparam logic [12:0] SCALE_RECIP = 13'd4370;
  localparam int          SCALE_SHIFT = 18;

  // (col + row) / 219, done as a multiply by a reciprocal
  localparam logic [14:0] MOD_RECIP = 15'd19153;
  localparam int          MOD_SHIFT = 22;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       chroma_valid;
    logic       outside_frame;
  } out_item_t;

  // Values derived from the configuration registers
  typedef struct packed {
    logic [DIM_W-1:0]   w_use;
    logic [DIM_W-1:0]   h_use;
    logic [COORD_W-1:0] w_half;
    logic [COORD_W-1:0] h_half;
    logic [SCALE_W-1:0] scale;
    logic [GW_W-1:0]    gw;
    logic [BOXH_W-1:0]  box_h;
  } dims_t;

  // 5x7 font, one row per entry, MSB is the leftmost dot
  localparam logic [4:0] GLYPH [10][7] = '{
    '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
    '{5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},
    '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
    '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C}
  };

  // Font row lookup; codes above nine and rows past the glyph are dark
  function automatic logic [4:0] glyph_row(input logic [3:0] d, input logic [2:0] row);
    logic [4:0] bits;
    bits = 5'd0;
    if (d <= 4'd9 && row <= 3'd6) begin
      bits = GLYPH[d][row];
    end
    return bits;
  endfunction

  // Clamp a dimension to the legal range and round it down to even
  function automatic logic [DIM_W-1:0] usable_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] c;
    c = v;
    if (c < DIM_MIN) begin
      c = DIM_MIN;
    end else if (c > DIM_MAX) begin
      c = DIM_MAX;
    end
    return {c[DIM_W-1:1], 1'b0};
  endfunction

endpackage

@@ rtl/vtpg_cfg.sv @@
// ----------------------------------------------------------------------------
// vtpg_cfg
// Frame size registers and the box geometry derived from them.
// ----------------------------------------------------------------------------
module vtpg_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vtpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vtpg_pkg::DIM_W-1:0]    cfg_data,
  output vtpg_pkg::dims_t               dims
);

  logic [vtpg_pkg::DIM_W-1:0] frame_width;
  logic [vtpg_pkg::DIM_W-1:0] frame_height;
  vtpg_pkg::dims_t            dims_next;
  logic [25:0]                scale_prod;
  logic [vtpg_pkg::SCALE_W-1:0] scale_raw;

  assign cfg_ready = 1'b1;

  // Write the registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= vtpg_pkg::WIDTH_RST;
      frame_height <= vtpg_pkg::HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vtpg_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        vtpg_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Derive usable sizes, digit scale and box sizes
  always_comb begin
    dims_next.w_use  = vtpg_pkg::usable_dim(frame_width);
    dims_next.h_use  = vtpg_pkg::usable_dim(frame_height);
    dims_next.w_half = dims_next.w_use[vtpg_pkg::DIM_W-1:1];
    dims_next.h_half = dims_next.h_use[vtpg_pkg::DIM_W-1:1];
    scale_prod = 26'(dims_next.h_use) * 26'(vtpg_pkg::SCALE_RECIP);
    scale_raw  = scale_prod[vtpg_pkg::SCALE_SHIFT +: vtpg_pkg::SCALE_W];
    dims_next.scale = (scale_raw == '0) ? vtpg_pkg::SCALE_W'(1) : scale_raw;
    dims_next.gw    = vtpg_pkg::GW_W'(dims_next.scale) * vtpg_pkg::GW_W'(6);
    dims_next.box_h = vtpg_pkg::BOXH_W'(dims_next.scale) * vtpg_pkg::BOXH_W'(9);
  end

  always_ff @(posedge clk) begin
    dims <= dims_next;
  end

endmodule

@@ rtl/vtpg_frame_ctr.sv @@
// ----------------------------------------------------------------------------
// vtpg_frame_ctr
// BCD frame number, significant digit count and stripe phase.
// ----------------------------------------------------------------------------
module vtpg_frame_ctr #(
  parameter int MAX_DIGITS = 20,
  parameter int CNT_W      = 5,
  parameter int IDX_W      = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [IDX_W-1:0]              rd_idx,
  output logic [3:0]                    rd_digit,
  output logic [CNT_W-1:0]              digit_count,
  output logic [vtpg_pkg::PHASE_W-1:0]  stripe_phase
);

  logic [3:0]               frame_digits      [MAX_DIGITS];
  logic [3:0]               frame_digits_next [MAX_DIGITS];
  logic [CNT_W-1:0]         digit_count_next;
  logic [vtpg_pkg::PHASE_W-1:0] stripe_phase_next;
  logic [vtpg_pkg::PHASE_W:0]   phase_sum;
  logic                     carry;
  logic [CNT_W-1:0]         top_pos;

  assign rd_digit = frame_digits[rd_idx];

  // Increment with carry; the highest changed digit bounds the count
  always_comb begin
    carry   = 1'b1;
    top_pos = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      frame_digits_next[i] = frame_digits[i];
      if (carry) begin
        if (frame_digits[i] >= 4'd9) begin
          frame_digits_next[i] = 4'd0;
        end else begin
          frame_digits_next[i] = frame_digits[i] + 4'd1;
          carry   = 1'b0;
          top_pos = CNT_W'(i + 1);
        end
      end
    end
    if (carry) begin
      digit_count_next = CNT_W'(1);
    end else if (top_pos > digit_count) begin
      digit_count_next = top_pos;
    end else begin
      digit_count_next = digit_count;
    end
    phase_sum = {1'b0, stripe_phase} + {1'b0, vtpg_pkg::PHASE_STEP};
    if (phase_sum >= {1'b0, vtpg_pkg::Y_SPAN}) begin
      phase_sum = phase_sum - {1'b0, vtpg_pkg::Y_SPAN};
    end
    stripe_phase_next = phase_sum[vtpg_pkg::PHASE_W-1:0];
  end

  // Step to the next frame on an advance item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        frame_digits[i] <= 4'd0;
      end
      digit_count  <= CNT_W'(1);
      stripe_phase <= '0;
    end else if (advance) begin
      frame_digits <= frame_digits_next;
      digit_count  <= digit_count_next;
      stripe_phase <= stripe_phase_next;
    end
  end

endmodule

@@ rtl/vtpg_pipe.sv @@
// ----------------------------------------------------------------------------
// vtpg_pipe
// Pixel pipeline: bound checks, gradient and glyph dividers, state read and
// final pixel mux, with an output register.
// ----------------------------------------------------------------------------
module vtpg_pipe #(
  parameter int MAX_DIGITS = 20,
  parameter int CNT_W      = 5,
  parameter int IDX_W      = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  vtpg_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output vtpg_pkg::out_item_t          out_item,
  input  vtpg_pkg::dims_t              dims,
  output logic                         advance,
  output logic [IDX_W-1:0]             rd_idx,
  input  logic [3:0]                   rd_digit,
  input  logic [CNT_W-1:0]             digit_count,
  input  logic [vtpg_pkg::PHASE_W-1:0] stripe_phase
);

  localparam int DV_W   = 13 + CNT_W;
  localparam int BW_W   = $clog2(vtpg_pkg::GW_MAX * MAX_DIGITS + vtpg_pkg::SCALE_MAX + 1);
  localparam int CMP_W  = (BW_W + 1 > vtpg_pkg::COORD_W) ? BW_W + 1 : vtpg_pkg::COORD_W + 1;
  localparam int GI_LO  = CNT_W / 2;
  localparam int QC_W   = 19;
  localparam int BOXH_W_L = vtpg_pkg::BOXH_W + 1;

  typedef struct packed {
    logic             mode;
    logic [11:0]      c;
    logic [11:0]      r;
    logic             outside;
    logic             cv;
    logic [12:0]      sum;
    logic [5:0]       mq;
    logic [7:0]       lm;
    logic [QC_W-1:0]  u_rem;
    logic [6:0]       u_q;
    logic [QC_W-1:0]  v_rem;
    logic [6:0]       v_q;
    logic             under;
    logic [DV_W-1:0]  x_rem;
    logic [CNT_W-1:0] gi;
    logic [2:0]       gc;
    logic [12:0]      gr_rem;
    logic [2:0]       gr;
    logic [CNT_W-1:0] n;
    logic             dig_ok;
    logic [3:0]       digit;
    logic [BW_W-1:0]  boxw;
  } stage_t;

  logic   pipe_en;
  logic   v1, v2, v3, v4, v5, v6;
  stage_t s1, s2, s3, s4, s5, s6;
  stage_t s1_next, s2_next, s3_next, s4_next, s5_next, s6_next;
  vtpg_pkg::out_item_t out_next;
  logic [27:0] mod_prod;
  logic [12:0] lm_full;
  logic [8:0]  lsum;
  logic [CNT_W-1:0] idx_full;
  logic [CMP_W-1:0] boxw_x, boxw_even, c_x;
  logic [BOXH_W_L-1:0] box_h_even;
  logic        in_lbox, in_cbox, lit;
  logic [4:0]  row_bits;

  // The whole pipe moves while the output register can take an item
  assign pipe_en  = !out_valid || !out_stall;
  assign in_stall = !pipe_en;
  assign advance  = pipe_en && v5 && s5.mode;

  // Capture the input item with the working fields cleared
  always_comb begin
    s1_next      = '0;
    s1_next.mode = in_item.mode;
    s1_next.c    = in_item.pixel_col;
    s1_next.r    = in_item.pixel_row;
  end

  // Bounds, stripe sum, divider numerators
  always_comb begin
    s2_next         = s1;
    s2_next.outside = (13'(s1.c) >= dims.w_use) || (13'(s1.r) >= dims.h_use);
    s2_next.cv      = !s1.c[0] && !s1.r[0];
    s2_next.sum     = 13'(s1.c) + 13'(s1.r);
    mod_prod        = 28'(s2_next.sum) * 28'(vtpg_pkg::MOD_RECIP);
    s2_next.mq      = mod_prod[vtpg_pkg::MOD_SHIFT +: 6];
    s2_next.u_rem   = QC_W'({s1.c[11:1], 7'd0});
    s2_next.v_rem   = QC_W'({s1.r[11:1], 7'd0});
    s2_next.u_q     = '0;
    s2_next.v_q     = '0;
    s2_next.under   = (s1.c < 12'(dims.scale)) || (s1.r < 12'(dims.scale));
    s2_next.x_rem   = DV_W'(s1.c - 12'(dims.scale));
    s2_next.gr_rem  = 13'(s1.r - 12'(dims.scale));
    s2_next.gi      = '0;
    s2_next.gc      = '0;
    s2_next.gr      = '0;
  end

  // Stripe residue; upper gradient bits, upper digit index bits, glyph row
  always_comb begin
    s3_next = s2;
    lm_full = s2.sum - 13'(s2.mq) * 13'(vtpg_pkg::Y_SPAN);
    s3_next.lm = lm_full[7:0];
    for (int i = 6; i >= 4; i--) begin
      if (s3_next.u_rem >= (QC_W'(dims.w_half) << i)) begin
        s3_next.u_rem  = s3_next.u_rem - (QC_W'(dims.w_half) << i);
        s3_next.u_q[i] = 1'b1;
      end
      if (s3_next.v_rem >= (QC_W'(dims.h_half) << i)) begin
        s3_next.v_rem  = s3_next.v_rem - (QC_W'(dims.h_half) << i);
        s3_next.v_q[i] = 1'b1;
      end
    end
    for (int i = CNT_W - 1; i >= GI_LO; i--) begin
      if (s3_next.x_rem >= (DV_W'(dims.gw) << i)) begin
        s3_next.x_rem = s3_next.x_rem - (DV_W'(dims.gw) << i);
        s3_next.gi[i] = 1'b1;
      end
    end
    for (int i = 2; i >= 0; i--) begin
      if (s3_next.gr_rem >= (13'(dims.scale) << i)) begin
        s3_next.gr_rem = s3_next.gr_rem - (13'(dims.scale) << i);
        s3_next.gr[i]  = 1'b1;
      end
    end
  end

  // Middle gradient bits, lower digit index bits
  always_comb begin
    s4_next = s3;
    for (int i = 3; i >= 1; i--) begin
      if (s4_next.u_rem >= (QC_W'(dims.w_half) << i)) begin
        s4_next.u_rem  = s4_next.u_rem - (QC_W'(dims.w_half) << i);
        s4_next.u_q[i] = 1'b1;
      end
      if (s4_next.v_rem >= (QC_W'(dims.h_half) << i)) begin
        s4_next.v_rem  = s4_next.v_rem - (QC_W'(dims.h_half) << i);
        s4_next.v_q[i] = 1'b1;
      end
    end
    for (int i = GI_LO - 1; i >= 0; i--) begin
      if (s4_next.x_rem >= (DV_W'(dims.gw) << i)) begin
        s4_next.x_rem = s4_next.x_rem - (DV_W'(dims.gw) << i);
        s4_next.gi[i] = 1'b1;
      end
    end
  end

  // Last gradient bit, column inside the glyph cell
  always_comb begin
    s5_next = s4;
    if (s5_next.u_rem >= QC_W'(dims.w_half)) begin
      s5_next.u_rem  = s5_next.u_rem - QC_W'(dims.w_half);
      s5_next.u_q[0] = 1'b1;
    end
    if (s5_next.v_rem >= QC_W'(dims.h_half)) begin
      s5_next.v_rem  = s5_next.v_rem - QC_W'(dims.h_half);
      s5_next.v_q[0] = 1'b1;
    end
    for (int i = 2; i >= 0; i--) begin
      if (s5_next.x_rem >= (DV_W'(dims.scale) << i)) begin
        s5_next.x_rem = s5_next.x_rem - (DV_W'(dims.scale) << i);
        s5_next.gc[i] = 1'b1;
      end
    end
  end

  // Read frame state: phase, digit count and the digit under this cell
  assign idx_full = digit_count - CNT_W'(1) - s5.gi;
  assign rd_idx   = idx_full[IDX_W-1:0];

  always_comb begin
    s6_next = s5;
    lsum    = 9'(s5.lm) + 9'(stripe_phase);
    if (lsum >= 9'(vtpg_pkg::Y_SPAN)) begin
      lsum = lsum - 9'(vtpg_pkg::Y_SPAN);
    end
    s6_next.lm     = lsum[7:0];
    s6_next.n      = digit_count;
    s6_next.dig_ok = s5.gi < digit_count;
    s6_next.digit  = s6_next.dig_ok ? rd_digit : 4'd0;
    s6_next.boxw   = BW_W'(dims.gw) * BW_W'(digit_count) + BW_W'(dims.scale);
  end

  // Box tests, font lookup and final pixel values
  always_comb begin
    boxw_x     = CMP_W'(s6.boxw);
    boxw_even  = (boxw_x + CMP_W'(1)) & ~CMP_W'(1);
    box_h_even = (BOXH_W_L'(dims.box_h) + BOXH_W_L'(1)) & ~BOXH_W_L'(1);
    c_x        = CMP_W'(s6.c);
    in_lbox    = (c_x < boxw_x) && (s6.r < 12'(dims.box_h));
    in_cbox    = (c_x < boxw_even) && (13'(s6.r) < 13'(box_h_even));
    row_bits   = vtpg_pkg::glyph_row(s6.digit, s6.gr);
    lit        = !s6.under && (s6.gr < 3'd7) && s6.dig_ok && (s6.gc < 3'd5) &&
                 ((row_bits & (5'h10 >> s6.gc)) != 5'd0);
    if (s6.outside) begin
      out_next.luma          = 8'd0;
      out_next.chroma_u      = 8'd0;
      out_next.chroma_v      = 8'd0;
      out_next.chroma_valid  = 1'b0;
      out_next.outside_frame = 1'b1;
    end else begin
      out_next.luma          = vtpg_pkg::Y_LO + s6.lm;
      if (in_lbox) begin
        out_next.luma = lit ? vtpg_pkg::Y_HI : vtpg_pkg::Y_LO;
      end
      out_next.chroma_u      = vtpg_pkg::C_BASE + 8'(s6.u_q);
      out_next.chroma_v      = vtpg_pkg::C_BASE + 8'(s6.v_q);
      if (in_cbox) begin
        out_next.chroma_u = vtpg_pkg::NEUTRAL;
        out_next.chroma_v = vtpg_pkg::NEUTRAL;
      end
      out_next.chroma_valid  = s6.cv;
      out_next.outside_frame = 1'b0;
    end
  end

  // Advance valid bits; advance items end at the state stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (pipe_en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5 && !s5.mode;
      out_valid <= v6;
    end
  end

  // Move payload
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1       <= s1_next;
      s2       <= s2_next;
      s3       <= s3_next;
      s4       <= s4_next;
      s5       <= s5_next;
      s6       <= s6_next;
      out_item <= out_next;
    end
  end

endmodule

@@ rtl/video_test_pattern_gen_unit.sv @@
// ----------------------------------------------------------------------------
// video_test_pattern_gen_unit
// YUV 4:2:0 test pattern generator: diagonal luma stripe, U/V gradients and a
// frame number box, one pixel per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_item): mode 0 asks for the pixel at
//   pixel_col, pixel_row; mode 1 steps to the next frame and gives no result.
//   Output channel (out_valid / out_stall / out_item): one item per pixel
//   request, in request order.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): frame
//   width and height; write only while no item is in flight. cfg_ready is
//   always high.
//   The pipeline has seven registers, in which the gradient and glyph
//   dividers retire a few quotient bits per stage; it takes one item per
//   cycle while the output is not stalled.
//   Reset clears the frame number to zero, the stripe phase to zero and the
//   size to 640x480, and empties the pipeline.
//   When the receiver stalls, the whole pipeline holds and in_stall rises
//   while the output register is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module video_test_pattern_gen_unit #(
  parameter int MAX_DIGITS = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  vtpg_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output vtpg_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vtpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vtpg_pkg::DIM_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  vtpg_pkg::dims_t              dims;
  logic                         advance;
  logic [IDX_W-1:0]             rd_idx;
  logic [3:0]                   rd_digit;
  logic [CNT_W-1:0]             digit_count;
  logic [vtpg_pkg::PHASE_W-1:0] stripe_phase;

  vtpg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dims      (dims)
  );

  vtpg_frame_ctr #(
    .MAX_DIGITS (MAX_DIGITS),
    .CNT_W      (CNT_W),
    .IDX_W      (IDX_W)
  ) u_frame_ctr (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .rd_idx       (rd_idx),
    .rd_digit     (rd_digit),
    .digit_count  (digit_count),
    .stripe_phase (stripe_phase)
  );

  vtpg_pipe #(
    .MAX_DIGITS (MAX_DIGITS),
    .CNT_W      (CNT_W),
    .IDX_W      (IDX_W)
  ) u_pipe (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item),
    .dims         (dims),
    .advance      (advance),
    .rd_idx       (rd_idx),
    .rd_digit     (rd_digit),
    .digit_count  (digit_count),
    .stripe_phase (stripe_phase)
  );

  // An empty output register never pushes back on the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

  // In-frame luma stays in video range
  a_luma_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.outside_frame |->
      out_item.luma >= vtpg_pkg::Y_LO && out_item.luma <= vtpg_pkg::Y_HI)
    else $error("luma out of range");

  // In-frame chroma stays within the gradient span
  a_chroma_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.outside_frame |->
      out_item.chroma_u >= 8'd64 && out_item.chroma_u < 8'd192 &&
      out_item.chroma_v >= 8'd64 && out_item.chroma_v < 8'd192)
    else $error("chroma out of range");

  // Out-of-frame pixels carry all-zero samples
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.outside_frame |->
      out_item.luma == 8'd0 && out_item.chroma_u == 8'd0 &&
      out_item.chroma_v == 8'd0 && !out_item.chroma_valid)
    else $error("outside pixel not blanked");

endmodule
